>>> src/lms_pkg.sv
package lms_pkg;

  // Field widths
  localparam int unsigned TickW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned SegW    = 8;
  localparam int unsigned ReplyW  = 3;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned OutW    = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned ApbW    = 32;

  // Reset values of the configuration registers; period step (also the period reset) and limits
  localparam logic [TickW-1:0] PhaseOneReset   = 10'd500;
  localparam logic [TickW-1:0] PhaseTwoReset   = 10'd200;
  localparam logic [TickW-1:0] PhaseThreeReset = 10'd300;
  localparam logic [TickW-1:0] PeriodStep      = 10'd100;
  localparam logic [TickW-1:0] PeriodMax       = 10'd900;
  localparam logic [TickW-1:0] TickMax         = 10'd1023;

  // Serial command characters
  localparam logic [ByteW-1:0] CharZero = 8'h30;
  localparam logic [ByteW-1:0] CharOne  = 8'h31;
  localparam logic [ByteW-1:0] CharTwo  = 8'h32;

  // Register indexes
  localparam logic [1:0] RegPhaseOne   = 2'd0;
  localparam logic [1:0] RegPhaseTwo   = 2'd1;
  localparam logic [1:0] RegPhaseThree = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_STEP = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_PHASED = 2'd0,
    MODE_CHASE  = 2'd1,
    MODE_FLASH  = 2'd2,
    MODE_COUNT  = 2'd3
  } run_mode_e;

  typedef enum logic [1:0] {
    PHASE_ONE   = 2'd0,
    PHASE_TWO   = 2'd1,
    PHASE_THREE = 2'd2,
    PHASE_SPARE = 2'd3
  } light_phase_e;

  typedef enum logic [ReplyW-1:0] {
    REPLY_NONE   = 3'd0,
    REPLY_NORMAL = 3'd1,
    REPLY_CHASE  = 3'd2,
    REPLY_BLINK  = 3'd3,
    REPLY_BAD    = 3'd4
  } reply_code_e;

  typedef struct packed {
    logic [ReplyW-1:0] reply_code;
    logic [SegW-1:0]   digit7_segments;
    logic              digit7_write;
    logic [SegW-1:0]   digit5_segments;
    logic              digit5_write;
    logic [SegW-1:0]   led_port;
  } result_t;

  // Hundreds digit of a tick value, saturated at nine
  function automatic logic [IdxW-1:0] hundreds_of(input logic [TickW-1:0] v);
    logic [IdxW-1:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= TickW'(k * 100)) d = IdxW'(k);
    end
    return d;
  endfunction

  // Seven-segment pattern; values above nine show nine
  function automatic logic [SegW-1:0] seg_of(input logic [IdxW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      default: s = 8'h6F;
    endcase
    return s;
  endfunction

  // Chase fill pattern, active low
  function automatic logic [SegW-1:0] fill_of(input logic [IdxW-1:0] i);
    logic [SegW-1:0] f;
    case (i)
      4'd0:    f = 8'hFF;
      4'd1:    f = 8'hFE;
      4'd2:    f = 8'hFC;
      4'd3:    f = 8'hF8;
      4'd4:    f = 8'hF0;
      4'd5:    f = 8'hE0;
      4'd6:    f = 8'hC0;
      4'd7:    f = 8'h80;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

>>> src/led_mode_sequencer.sv
// Light and digit sequencer. Each input transaction is a millisecond tick, a
// received serial character or a period-step button press, and produces exactly
// one result transaction with the port value, the two digit writes and a reply
// code. The block takes one transaction per cycle; a result passes the input
// register, then a single compute stage into the result register. The input
// side keeps accepting while a result waits, stalling only when both registers
// are full and m_axis_tready is low. The user is to write the three phase
// lengths over the APB port only while the stream is idle; nothing enforces it.
module led_mode_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lms_pkg::ByteW-1:0]       s_axis_tdata,  // [7:0] rx_byte
  input  logic [lms_pkg::ReqW-1:0]        s_axis_tuser,  // [1:0] req_type
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] led_port, [8] digit5_write, [16:9] digit5_segments, [17] digit7_write,
  // [25:18] digit7_segments, [28:26] reply_code, [31:29] zero
  output logic [lms_pkg::OutW-1:0]        m_axis_tdata,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lms_pkg::AddrW-1:0]       paddr,
  input  logic [lms_pkg::ApbW-1:0]        pwdata,
  output logic [lms_pkg::ApbW-1:0]        prdata,
  output logic                            pready
);

  localparam int unsigned TW = lms_pkg::TickW;
  localparam int unsigned IW = lms_pkg::IdxW;
  localparam int unsigned BW = lms_pkg::ByteW;

  // Configuration registers
  logic [TW-1:0] phase_one_q, phase_two_q, phase_three_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_one_q   <= lms_pkg::PhaseOneReset;
      phase_two_q   <= lms_pkg::PhaseTwoReset;
      phase_three_q <= lms_pkg::PhaseThreeReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lms_pkg::RegPhaseOne:   phase_one_q   <= pwdata[TW-1:0];
        lms_pkg::RegPhaseTwo:   phase_two_q   <= pwdata[TW-1:0];
        lms_pkg::RegPhaseThree: phase_three_q <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[3:2])
      lms_pkg::RegPhaseOne:   prdata = {{(lms_pkg::ApbW-TW){1'b0}}, phase_one_q};
      lms_pkg::RegPhaseTwo:   prdata = {{(lms_pkg::ApbW-TW){1'b0}}, phase_two_q};
      lms_pkg::RegPhaseThree: prdata = {{(lms_pkg::ApbW-TW){1'b0}}, phase_three_q};
      default:                prdata = '0;
    endcase
  end

  // Input register and handshake
  logic                in_vld_q;
  lms_pkg::req_type_e  req_q;
  logic [BW-1:0]       byte_q;
  logic                out_vld_q;
  lms_pkg::result_t    res_q, res_d;
  logic                advance;

  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q  <= lms_pkg::req_type_e'(s_axis_tuser);
      byte_q <= s_axis_tdata;
    end
  end

  // Sequencer state
  lms_pkg::run_mode_e    mode_q, mode_d;
  lms_pkg::light_phase_e phase_q, phase_d;
  logic [TW-1:0]         timer_q, timer_d;
  logic [TW-1:0]         ticks_q, ticks_d;
  logic [IW-1:0]         chase_q, chase_d;
  logic                  blink_q, blink_d;
  logic [IW-1:0]         blinks_q, blinks_d;
  logic [TW-1:0]         period_q, period_d;
  logic [BW-1:0]         first_q, first_d;
  logic                  have_first_q, have_first_d;
  logic [BW-1:0]         port_q, port_d;

  // Compute helpers
  logic [TW-1:0] len;
  logic [2:0]    low;
  logic [TW-1:0] timer_inc;
  logic [TW-1:0] ticks_inc;
  logic [TW-1:0] remain;
  logic [IW-1:0] idx;
  logic [IW-1:0] blinks_inc;
  logic [TW:0]   period_inc;

  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    timer_d      = timer_q;
    ticks_d      = ticks_q;
    chase_d      = chase_q;
    blink_d      = blink_q;
    blinks_d     = blinks_q;
    period_d     = period_q;
    first_d      = first_q;
    have_first_d = have_first_q;
    port_d       = port_q;
    res_d        = '0;

    // Phase length and lamp code of the current light
    case (phase_q)
      lms_pkg::PHASE_TWO:   begin len = phase_two_q;   low = 3'b101; end
      lms_pkg::PHASE_THREE: begin len = phase_three_q; low = 3'b011; end
      default:              begin len = phase_one_q;   low = 3'b110; end
    endcase

    timer_inc  = timer_q + TW'(1);
    ticks_inc  = (ticks_q < lms_pkg::TickMax) ? ticks_q + TW'(1) : ticks_q;
    idx        = (chase_q > IW'(8)) ? '0 : chase_q;
    blinks_inc = blinks_q + IW'(1);
    period_inc = {1'b0, period_q} + {1'b0, lms_pkg::PeriodStep};
    remain     = '0;

    case (req_q)
      lms_pkg::REQ_TICK: begin
        case (mode_q)
          lms_pkg::MODE_PHASED: begin
            ticks_d = '0;
            timer_d = timer_inc;
            port_d  = {port_q[7:3], low};
            // End the phase and move to the next light
            if (timer_inc >= len) begin
              timer_d = '0;
              case (phase_q)
                lms_pkg::PHASE_ONE:   phase_d = lms_pkg::PHASE_TWO;
                lms_pkg::PHASE_TWO:   phase_d = lms_pkg::PHASE_THREE;
                lms_pkg::PHASE_THREE: phase_d = lms_pkg::PHASE_ONE;
                default:              phase_d = lms_pkg::PHASE_TWO;
              endcase
            end
            remain = (len >= timer_d) ? len - timer_d : '0;
            res_d.digit7_write    = 1'b1;
            res_d.digit7_segments = lms_pkg::seg_of(lms_pkg::hundreds_of(remain));
            res_d.digit5_write    = 1'b1;
            res_d.digit5_segments = lms_pkg::seg_of(lms_pkg::hundreds_of(period_q));
          end
          lms_pkg::MODE_CHASE: begin
            ticks_d = ticks_inc;
            // Take one chase step per period
            if (ticks_inc >= period_q) begin
              ticks_d               = '0;
              res_d.digit5_write    = 1'b1;
              res_d.digit5_segments = lms_pkg::seg_of(idx);
              port_d                = lms_pkg::fill_of(idx);
              chase_d               = (idx >= IW'(8)) ? '0 : idx + IW'(1);
            end
          end
          lms_pkg::MODE_FLASH: begin
            ticks_d = ticks_inc;
            // Toggle the port once per period, count full blinks
            if (ticks_inc >= period_q) begin
              ticks_d            = '0;
              res_d.digit5_write = 1'b1;
              if (!blink_q) begin
                port_d                = '0;
                blink_d               = 1'b1;
                res_d.digit5_segments = lms_pkg::seg_of(IW'(0));
              end else begin
                port_d                = '1;
                blink_d               = 1'b0;
                res_d.digit5_segments = lms_pkg::seg_of(IW'(8));
                if (blinks_inc >= IW'(8)) begin
                  blinks_d = '0;
                end else begin
                  blinks_d = blinks_inc;
                end
              end
              if (blinks_q >= IW'(8)) begin
                blinks_d = '0;
                blink_d  = 1'b0;
              end
            end
          end
          default: ticks_d = ticks_inc;
        endcase
      end
      lms_pkg::REQ_BYTE: begin
        if (!have_first_q) begin
          first_d      = byte_q;
          have_first_d = 1'b1;
        end else begin
          have_first_d = 1'b0;
          // Decode the character pair
          if (first_q == lms_pkg::CharZero && byte_q == lms_pkg::CharZero) begin
            mode_d           = lms_pkg::MODE_PHASED;
            phase_d          = lms_pkg::PHASE_ONE;
            timer_d          = '0;
            res_d.reply_code = lms_pkg::REPLY_NORMAL;
          end else if (first_q == lms_pkg::CharZero && byte_q == lms_pkg::CharOne) begin
            mode_d           = lms_pkg::MODE_CHASE;
            res_d.reply_code = lms_pkg::REPLY_CHASE;
          end else if (first_q == lms_pkg::CharZero && byte_q == lms_pkg::CharTwo) begin
            mode_d           = lms_pkg::MODE_FLASH;
            blinks_d         = '0;
            blink_d          = 1'b0;
            ticks_d          = '0;
            res_d.reply_code = lms_pkg::REPLY_BLINK;
          end else begin
            res_d.reply_code = lms_pkg::REPLY_BAD;
          end
        end
      end
      lms_pkg::REQ_STEP: begin
        // Step the period, wrap past the top
        period_d = (period_inc > {1'b0, lms_pkg::PeriodMax}) ?
                   lms_pkg::PeriodStep : period_inc[TW-1:0];
      end
      default: ;
    endcase

    res_d.led_port = port_d;
  end

  // State update on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lms_pkg::MODE_PHASED;
      phase_q      <= lms_pkg::PHASE_ONE;
      timer_q      <= '0;
      ticks_q      <= '0;
      chase_q      <= '0;
      blink_q      <= 1'b0;
      blinks_q     <= '0;
      period_q     <= lms_pkg::PeriodStep;
      first_q      <= '0;
      have_first_q <= 1'b0;
      port_q       <= '1;
    end else if (advance) begin
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      ticks_q      <= ticks_d;
      chase_q      <= chase_d;
      blink_q      <= blink_d;
      blinks_q     <= blinks_d;
      period_q     <= period_d;
      first_q      <= first_d;
      have_first_q <= have_first_d;
      port_q       <= port_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(lms_pkg::OutW - $bits(lms_pkg::result_t)){1'b0}}, res_q};

  // Checks
  a_chase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chase_q <= IW'(8))
    else $error("chase index out of range");

  a_blink_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blinks_q < IW'(8))
    else $error("blink count out of range");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q >= lms_pkg::PeriodStep && period_q <= lms_pkg::PeriodMax)
    else $error("step period out of range");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed transaction left no result");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stalled while input register empty");

endmodule
